### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types and codes for the binary min-heap priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CMP,
    S_WRITE_KEY,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// heap storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic      [DW-1:0] rdata0,
  output logic      [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

### rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// priority queue of signed 32-bit keys kept as a binary min-heap in memory
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: one request per item, in_operation selects insert or
//   remove of the smallest key; in_value is the key to insert.
//   out_* channel: one result per request with the removed key, a status
//   (done, full, empty) and the occupancy after the request.
//   cfg_wr_en/cfg_wr_data set the capacity; write only while idle.
//   An insert or remove moves the key over at most log2 of the entry count
//   heap levels. At each level the heap memory gives a registered read of
//   the parent or both children and takes a write of the moved entry. One
//   request is worked on at a time; the next is accepted only after the
//   result of the last is loaded. Rejected and empty requests skip the walk.
//   Reset empties the queue and sets the capacity to 64; no clearing pass.
//   A stalled result is held in the output register; the next request is
//   still accepted and its result waits until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue #(
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_operation,
  input  wire logic signed [bmhq_pkg::KEY_W-1:0]      in_value,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed      [bmhq_pkg::KEY_W-1:0]      out_removed_value,
  output bmhq_pkg::status_t                           out_status,
  output logic             [bmhq_pkg::CNT_W-1:0]      out_occupancy,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [bmhq_pkg::CNT_W-1:0]      cfg_wr_data
);

  import bmhq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int XW = (AW + 2 > CNT_W + 1) ? AW + 2 : CNT_W + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        cap_r;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] res_removed_r, res_removed_nxt;
  status_t                 res_status_r, res_status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_removed_r;
  status_t                 out_status_r;
  logic [CNT_W-1:0]        out_occ_r;

  // memory port
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr0, mem_raddr1;
  logic signed [KEY_W-1:0] rdata0, rdata1;

  // datapath helpers
  logic [XW-1:0]           count_x, kid_x, kid1_x, child_pos_x, new_kid_x;
  logic [AW-1:0]           par;
  logic                    accept, full, right_ok, take_right, sink, rise;
  logic                    new_kid_ok, out_free;
  logic signed [KEY_W-1:0] child_val;

  assign count_x     = XW'(count_r);
  assign kid_x       = XW'({pos_r, 1'b1});
  assign kid1_x      = kid_x + XW'(1);
  assign par         = AW'((pos_r - AW'(1)) >> 1);
  assign full        = (count_x >= XW'(cap_r)) || (count_x >= DEPTH_X);
  assign right_ok    = kid1_x < count_x;
  assign take_right  = right_ok && (rdata0 > rdata1);
  assign child_val   = take_right ? rdata1 : rdata0;
  assign child_pos_x = take_right ? kid1_x : kid_x;
  assign new_kid_x   = XW'({child_pos_x[AW-1:0], 1'b1});
  assign new_kid_ok  = new_kid_x < count_x;
  assign sink        = key_r > child_val;
  assign rise        = rdata0 > key_r;
  assign out_free    = !out_valid_r || !out_stall;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  bmhq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (KEY_W)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_INSERT) begin
            if (full || count_r == '0) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_UP_CMP;
            end
          end else begin
            if (count_r == '0) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_CMP: begin
        if (rise) begin
          state_nxt = (par == '0) ? S_WRITE_KEY : S_UP_CMP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DN_LOAD: begin
        state_nxt = (kid_x < count_x) ? S_DN_CMP : S_WRITE_KEY;
      end
      S_DN_CMP: begin
        if (sink) begin
          state_nxt = new_kid_ok ? S_DN_CMP : S_WRITE_KEY;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WRITE_KEY: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    key_nxt         = key_r;
    res_removed_nxt = res_removed_r;
    res_status_nxt  = res_status_r;
    mem_we          = 1'b0;
    mem_waddr       = pos_r;
    mem_wdata       = key_r;
    mem_raddr0      = kid_x[AW-1:0];
    mem_raddr1      = kid1_x[AW-1:0];
    out_valid_nxt   = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_removed_nxt = '0;
          res_status_nxt  = STAT_DONE;
          if (in_operation == OP_INSERT) begin
            if (full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              key_nxt    = in_value;
              count_nxt  = count_r + CNT_W'(1);
              pos_nxt    = count_x[AW-1:0];
              mem_raddr0 = AW'((count_x - XW'(1)) >> 1);
              if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_value;
              end
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              count_nxt  = count_r - CNT_W'(1);
              pos_nxt    = '0;
              mem_raddr0 = '0;
              mem_raddr1 = AW'(count_x - XW'(1));
            end
          end
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rise) begin
          mem_wdata  = rdata0;
          pos_nxt    = par;
          mem_raddr0 = AW'((par - AW'(1)) >> 1);
        end
      end
      S_DN_LOAD: begin
        res_removed_nxt = rdata0;
        key_nxt         = rdata1;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (sink) begin
          mem_wdata  = child_val;
          pos_nxt    = child_pos_x[AW-1:0];
          mem_raddr0 = new_kid_x[AW-1:0];
          mem_raddr1 = AW'(new_kid_x + XW'(1));
        end
      end
      S_WRITE_KEY: begin
        mem_we = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    key_r         <= key_nxt;
    res_removed_r <= res_removed_nxt;
    res_status_r  <= res_status_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_removed_r <= res_removed_r;
      out_status_r  <= res_status_r;
      out_occ_r     <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = out_occ_r;

`ifndef NO_ASSERTIONS
  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_x <= DEPTH_X)
    else $error("entry count above storage depth");

  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_CMP |-> pos_r != '0)
    else $error("sift-up compare at the root");

  a_dn_kid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DN_CMP |-> kid_x < count_x)
    else $error("sift-down child outside the heap");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_valid && state_r == S_IDLE)
    else $error("finished request not presented");

  a_result_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DONE) |-> out_removed_value == '0)
    else $error("nonzero key on a rejected request");
`endif

endmodule

`default_nettype wire
